@@ design/particle_integrate_and_bounce_unit_assert.svh @@
// Assertion macros for the particle integrate and bounce unit.
// Included by the top level; sampled on aclk, disabled while aresetn is low.
`ifndef PARTICLE_INTEGRATE_AND_BOUNCE_UNIT_ASSERT_SVH
`define PARTICLE_INTEGRATE_AND_BOUNCE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a condition at every clock edge.
`define PIBU_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("pibu assertion failed");
// Check that a trigger is followed by a consequence in the following cycle.
`define PIBU_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("pibu assertion failed");
`else
`define PIBU_ASSERT(lbl, cond)
`define PIBU_ASSERT_NEXT(lbl, trig, cons)
`endif
`endif

@@ design/pibu_pkg.sv @@
// Shared types, constants and saturation helper for the particle integrate unit.
// No dependencies.
package pibu_pkg;

    localparam int IDX_W     = 10;
    localparam int MOD_STEPS = 2;
    localparam int EW        = 38;
    localparam int DATA_W    = 208;
    localparam int SNAP_LIMIT = 6554;

    localparam logic [1:0] REG_TIME_STEP   = 2'd0;
    localparam logic [1:0] REG_BOX_WIDTH   = 2'd1;
    localparam logic [1:0] REG_BOX_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_DROP_RADIUS = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_RD,
        S_MULV,
        S_ADDV,
        S_MULP,
        S_ADDP,
        S_WEX,
        S_WPOS,
        S_WVEL,
        S_WB,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_ADD,
        OP_NEG
    } alu_op_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] new_pos;
    } wall_res_t;

    function automatic logic signed [31:0] sat32(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] max_v;
        logic signed [EW-1:0] min_v;
        max_v = EW'(32'sh7fffffff);
        min_v = -EW'(32'sh7fffffff) - EW'(1);
        if (v > max_v) begin
            return 32'sh7fffffff;
        end else if (v < min_v) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ design/pibu_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pibu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 3072
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/pibu_alu.sv @@
// Shared arithmetic unit: scaled multiply by the timestep, saturating add, negate.
// Depends on pibu_pkg.
module pibu_alu (
    input  pibu_pkg::alu_op_t   op,
    input  logic signed [31:0]  a,
    input  logic signed [31:0]  b,
    input  logic [16:0]         dt,
    output logic signed [31:0]  y
);

    logic signed [49:0] prod;
    logic signed [33:0] scaled;
    logic signed [pibu_pkg::EW-1:0] sum;
    logic signed [pibu_pkg::EW-1:0] neg;

    always_comb begin
        prod   = 50'(a) * 50'($signed({1'b0, dt}));
        // arithmetic shift rounds toward minus infinity
        scaled = prod[49:16];
        sum    = pibu_pkg::EW'(a) + pibu_pkg::EW'(b);
        neg    = -pibu_pkg::EW'(a);
        case (op)
            pibu_pkg::OP_MUL: y = pibu_pkg::sat32(pibu_pkg::EW'(scaled));
            pibu_pkg::OP_ADD: y = pibu_pkg::sat32(sum);
            pibu_pkg::OP_NEG: y = pibu_pkg::sat32(neg);
            default:          y = a;
        endcase
    end

endmodule

@@ design/pibu_wall.sv @@
// Wall test for one axis: excess beyond each wall, then snap or reflect.
// Depends on pibu_pkg.
module pibu_wall (
    input  logic signed [31:0]                pos,
    input  logic [30:0]                       size,
    input  logic [20:0]                       rad,
    input  logic signed [pibu_pkg::EW-1:0]    ex_lo_in,
    input  logic signed [pibu_pkg::EW-1:0]    ex_hi_in,
    output logic signed [pibu_pkg::EW-1:0]    ex_lo,
    output logic signed [pibu_pkg::EW-1:0]    ex_hi,
    output pibu_pkg::wall_res_t               res
);

    logic signed [pibu_pkg::EW-1:0] half;
    logic signed [pibu_pkg::EW-1:0] r;
    logic signed [pibu_pkg::EW-1:0] p;
    logic signed [pibu_pkg::EW-1:0] snap;
    logic signed [pibu_pkg::EW-1:0] np;

    always_comb begin
        half  = $signed(pibu_pkg::EW'(size[30:1]));
        r     = $signed(pibu_pkg::EW'(rad));
        p     = pibu_pkg::EW'(pos);
        snap  = pibu_pkg::EW'(pibu_pkg::SNAP_LIMIT);
        ex_lo = r - half - p;
        ex_hi = p + r - half;

        res.hit = 1'b0;
        np      = p;
        if (ex_lo_in > 0) begin
            res.hit = 1'b1;
            np = (ex_lo_in < snap) ? (r - half) : (p + (ex_lo_in <<< 1));
        end else if (ex_hi_in > 0) begin
            res.hit = 1'b1;
            np = (ex_hi_in < snap) ? (half - r) : (p - (ex_hi_in <<< 1));
        end
        res.new_pos = pibu_pkg::sat32(np);
    end

endmodule

@@ design/particle_integrate_and_bounce_unit.sv @@
// Drop table integrator: semi-implicit Euler step with wall reflection in Y, then X.
// A place item passes the index reduction (S_MOD), three writes (S_WB) and the output load
// (S_OUT); a step item adds, before the writes, per axis a read and multiply/add steps on
// the shared ALU (S_RD to S_ADDP), and per wall S_WEX, S_WPOS and S_WVEL. The next item is
// taken only once the result sits in the output register; that load waits on m_tready.
// aresetn (synchronous, active low) clears control and config; drop memory is not cleared.
module particle_integrate_and_bounce_unit #(
    parameter int DROP_COUNT = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata: drop_index[9:0], place_x, place_y, place_z, accel_x, accel_y,
    //          accel_z (32 bits each from bit 10 up), zero pad to 208
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pibu_pkg::DATA_W-1:0] s_tdata,
    // s_tuser: mode (0 place, 1 step)
    input  logic                        s_tuser,
    // m_tdata: out_index[9:0], new_pos_x, new_pos_y, new_pos_z, new_vel_x,
    //          new_vel_y, new_vel_z (32 bits each from bit 10 up), zero pad to 208
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pibu_pkg::DATA_W-1:0] m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int DEPTH  = 3 * DROP_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    // reciprocal of DROP_COUNT, exact for every index below 2**IDX_W
    localparam int MOD_SHIFT = pibu_pkg::IDX_W + $clog2(DROP_COUNT);
    localparam int MOD_MUL   = int'(((64'd1 << MOD_SHIFT) + 64'(DROP_COUNT) - 64'd1)
                                    / 64'(DROP_COUNT));

    pibu_pkg::state_t state_reg, state_next;

    logic [16:0] time_step_reg;
    logic [30:0] box_width_reg;
    logic [30:0] box_height_reg;
    logic [20:0] drop_radius_reg;

    logic [pibu_pkg::IDX_W-1:0] idx_reg;
    logic [pibu_pkg::IDX_W-1:0] r_reg;
    logic [pibu_pkg::IDX_W-1:0] quo_reg;
    logic [3:0]                 mstep_reg;
    logic                       mode_reg;
    logic [1:0]                 k_reg;
    logic                       ax_y_reg;
    logic                       hit_reg;

    logic signed [31:0] accel_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] cur_p_reg;
    logic signed [31:0] cur_v_reg;
    logic signed [31:0] acc_reg;
    logic signed [pibu_pkg::EW-1:0] ex_lo_reg;
    logic signed [pibu_pkg::EW-1:0] ex_hi_reg;

    logic [pibu_pkg::DATA_W-1:0] m_tdata_reg;
    logic                        m_tvalid_reg;

    logic [31:0]                mod_prod;
    logic [pibu_pkg::IDX_W-1:0] mod_quo;
    logic [31:0]                mod_sub;
    logic [ADDR_W-1:0]          ram_addr;
    logic                       ram_we;
    logic                       ram_re;
    logic [63:0]                ram_rdata;

    pibu_pkg::alu_op_t  alu_op;
    logic signed [31:0] alu_a;
    logic signed [31:0] alu_b;
    logic signed [31:0] alu_y;

    logic [1:0]                     axi;
    logic [30:0]                    wall_size;
    logic signed [pibu_pkg::EW-1:0] ex_lo_w;
    logic signed [pibu_pkg::EW-1:0] ex_hi_w;
    pibu_pkg::wall_res_t            wall_res;

    logic s_xfer;
    logic cfg_wr;
    logic out_load;

    assign s_tready = (state_reg == pibu_pkg::S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_load = (state_reg == pibu_pkg::S_OUT) && (!m_tvalid_reg || m_tready);

    assign mod_prod  = 32'(r_reg) * 32'(MOD_MUL);
    assign mod_quo   = pibu_pkg::IDX_W'(mod_prod >> MOD_SHIFT);
    assign mod_sub   = 32'(quo_reg) * 32'(DROP_COUNT);
    // slot * 3 + axis; the reduced index is below DROP_COUNT so this fits
    assign ram_addr  = ADDR_W'(r_reg) + ADDR_W'({r_reg, 1'b0}) + ADDR_W'(k_reg);
    assign axi       = ax_y_reg ? pibu_pkg::AXIS_Y : pibu_pkg::AXIS_X;
    assign wall_size = ax_y_reg ? box_height_reg : box_width_reg;

    pibu_ram #(
        .WIDTH(64),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata({pos_reg[k_reg], vel_reg[k_reg]}),
        .re   (ram_re),
        .raddr(ram_addr),
        .rdata(ram_rdata)
    );

    pibu_alu u_alu (
        .op(alu_op),
        .a (alu_a),
        .b (alu_b),
        .dt(time_step_reg),
        .y (alu_y)
    );

    pibu_wall u_wall (
        .pos     (pos_reg[axi]),
        .size    (wall_size),
        .rad     (drop_radius_reg),
        .ex_lo_in(ex_lo_reg),
        .ex_hi_in(ex_hi_reg),
        .ex_lo   (ex_lo_w),
        .ex_hi   (ex_hi_w),
        .res     (wall_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pibu_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        alu_op     = pibu_pkg::OP_ADD;
        alu_a      = cur_p_reg;
        alu_b      = acc_reg;
        case (state_reg)
            pibu_pkg::S_IDLE: begin
                if (s_tvalid) state_next = pibu_pkg::S_MOD;
            end
            pibu_pkg::S_MOD: begin
                if (mstep_reg == 4'd0) begin
                    state_next = mode_reg ? pibu_pkg::S_RD : pibu_pkg::S_WB;
                end
            end
            pibu_pkg::S_RD: begin
                ram_re     = 1'b1;
                state_next = pibu_pkg::S_MULV;
            end
            pibu_pkg::S_MULV: begin
                alu_op     = pibu_pkg::OP_MUL;
                alu_a      = accel_reg[k_reg];
                state_next = pibu_pkg::S_ADDV;
            end
            pibu_pkg::S_ADDV: begin
                alu_a      = cur_v_reg;
                state_next = pibu_pkg::S_MULP;
            end
            pibu_pkg::S_MULP: begin
                alu_op     = pibu_pkg::OP_MUL;
                alu_a      = cur_v_reg;
                state_next = pibu_pkg::S_ADDP;
            end
            pibu_pkg::S_ADDP: begin
                state_next = (k_reg == pibu_pkg::AXIS_LAST) ? pibu_pkg::S_WEX : pibu_pkg::S_RD;
            end
            pibu_pkg::S_WEX: begin
                state_next = pibu_pkg::S_WPOS;
            end
            pibu_pkg::S_WPOS: begin
                state_next = pibu_pkg::S_WVEL;
            end
            pibu_pkg::S_WVEL: begin
                alu_op     = pibu_pkg::OP_NEG;
                alu_a      = vel_reg[axi];
                state_next = ax_y_reg ? pibu_pkg::S_WEX : pibu_pkg::S_WB;
            end
            pibu_pkg::S_WB: begin
                ram_we = 1'b1;
                if (k_reg == pibu_pkg::AXIS_LAST) state_next = pibu_pkg::S_OUT;
            end
            pibu_pkg::S_OUT: begin
                if (!m_tvalid_reg || m_tready) state_next = pibu_pkg::S_IDLE;
            end
            default: begin
                state_next = pibu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mstep_reg <= '0;
            k_reg     <= '0;
            ax_y_reg  <= 1'b1;
            hit_reg   <= 1'b0;
        end else begin
            case (state_reg)
                pibu_pkg::S_IDLE: begin
                    if (s_xfer) begin
                        mstep_reg <= 4'(pibu_pkg::MOD_STEPS - 1);
                        k_reg     <= '0;
                        ax_y_reg  <= 1'b1;
                    end
                end
                pibu_pkg::S_MOD: begin
                    if (mstep_reg != 4'd0) mstep_reg <= mstep_reg - 4'd1;
                end
                pibu_pkg::S_ADDP, pibu_pkg::S_WB: begin
                    k_reg <= (k_reg == pibu_pkg::AXIS_LAST) ? 2'd0 : k_reg + 2'd1;
                end
                pibu_pkg::S_WPOS: begin
                    hit_reg <= wall_res.hit;
                end
                pibu_pkg::S_WVEL: begin
                    ax_y_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            pibu_pkg::S_IDLE: begin
                if (s_xfer) begin
                    idx_reg      <= s_tdata[9:0];
                    r_reg        <= s_tdata[9:0];
                    mode_reg     <= s_tuser;
                    pos_reg[0]   <= s_tdata[41:10];
                    pos_reg[1]   <= s_tdata[73:42];
                    pos_reg[2]   <= s_tdata[105:74];
                    accel_reg[0] <= s_tdata[137:106];
                    accel_reg[1] <= s_tdata[169:138];
                    accel_reg[2] <= s_tdata[201:170];
                    vel_reg[0]   <= '0;
                    vel_reg[1]   <= '0;
                    vel_reg[2]   <= '0;
                end
            end
            pibu_pkg::S_MOD: begin
                // quotient by reciprocal multiply first, then subtract its multiple
                if (mstep_reg != 4'd0) begin
                    quo_reg <= mod_quo;
                end else begin
                    r_reg <= r_reg - mod_sub[pibu_pkg::IDX_W-1:0];
                end
            end
            pibu_pkg::S_MULV: begin
                cur_p_reg <= ram_rdata[63:32];
                cur_v_reg <= ram_rdata[31:0];
                acc_reg   <= alu_y;
            end
            pibu_pkg::S_ADDV: begin
                cur_v_reg      <= alu_y;
                vel_reg[k_reg] <= alu_y;
            end
            pibu_pkg::S_MULP: begin
                acc_reg <= alu_y;
            end
            pibu_pkg::S_ADDP: begin
                pos_reg[k_reg] <= alu_y;
            end
            pibu_pkg::S_WEX: begin
                ex_lo_reg <= ex_lo_w;
                ex_hi_reg <= ex_hi_w;
            end
            pibu_pkg::S_WPOS: begin
                if (wall_res.hit) pos_reg[axi] <= wall_res.new_pos;
            end
            pibu_pkg::S_WVEL: begin
                if (hit_reg) vel_reg[axi] <= alu_y;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_tdata_reg <= {6'd0, vel_reg[2], vel_reg[1], vel_reg[0],
                            pos_reg[2], pos_reg[1], pos_reg[0], idx_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg   <= 17'd1092;
            box_width_reg   <= 31'd1310720;
            box_height_reg  <= 31'd1310720;
            drop_radius_reg <= 21'd6554;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pibu_pkg::REG_TIME_STEP:   time_step_reg   <= pwdata[16:0];
                pibu_pkg::REG_BOX_WIDTH:   box_width_reg   <= pwdata[30:0];
                pibu_pkg::REG_BOX_HEIGHT:  box_height_reg  <= pwdata[30:0];
                pibu_pkg::REG_DROP_RADIUS: drop_radius_reg <= pwdata[20:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pibu_pkg::REG_TIME_STEP:   prdata = 32'(time_step_reg);
            pibu_pkg::REG_BOX_WIDTH:   prdata = 32'(box_width_reg);
            pibu_pkg::REG_BOX_HEIGHT:  prdata = 32'(box_height_reg);
            pibu_pkg::REG_DROP_RADIUS: prdata = 32'(drop_radius_reg);
            default:                   prdata = '0;
        endcase
    end

`include "particle_integrate_and_bounce_unit_assert.svh"

    `PIBU_ASSERT_NEXT(a_busy_after_xfer, s_tvalid && s_tready, !s_tready)
    `PIBU_ASSERT_NEXT(a_slot_in_range, state_reg == pibu_pkg::S_MOD && mstep_reg == 4'd0,
                      32'(r_reg) < DROP_COUNT)
    `PIBU_ASSERT(a_axis_in_range, k_reg != 2'd3)

endmodule

@@ test/tb_particle_integrate_and_bounce_unit.sv @@
// Self-checking bench for particle_integrate_and_bounce_unit: place and step commands
// against a local drop table predictor, with random stalls on both stream sides.
// Depends on pibu_pkg for the register indexes and the stream width.
`timescale 1ns / 1ps

module tb_particle_integrate_and_bounce_unit;

    localparam int     DROP_COUNT  = 1024;
    localparam longint SNAP_EXCESS = 6554;
    localparam longint Q_MAX       = 64'sh7FFF_FFFF;
    localparam longint Q_MIN       = -64'sh8000_0000;
    localparam logic   MODE_PLACE  = 1'b0;
    localparam logic   MODE_STEP   = 1'b1;
    localparam int     PHASE_ITEMS = 257;

    typedef struct packed {
        logic             mode;
        logic [9:0]       idx;
        logic [2:0][31:0] place;
        logic [2:0][31:0] accel;
    } drop_cmd_t;

    typedef struct packed {
        logic [9:0]       idx;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
    } drop_state_t;

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [pibu_pkg::DATA_W-1:0] s_tdata  = '0;
    logic                        s_tuser  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [pibu_pkg::DATA_W-1:0] m_tdata;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [3:0]                  paddr    = '0;
    logic [31:0]                 pwdata   = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // predictor state and register copies
    logic signed [31:0] model_pos [3*DROP_COUNT];
    logic signed [31:0] model_vel [3*DROP_COUNT];
    longint cfg_dt     = 1092;
    longint cfg_width  = 1310720;
    longint cfg_height = 1310720;
    longint cfg_radius = 6554;

    drop_cmd_t   cmd_queue [$];
    drop_state_t expected_states [$];
    int          active_drops [$];
    int          error_count = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    particle_integrate_and_bounce_unit #(.DROP_COUNT(DROP_COUNT)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [31:0] clamp_q32(input longint v);
        if (v > Q_MAX) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < Q_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // q * dt, floored back to Q16.16
    function automatic logic signed [31:0] scale_by_dt(input logic signed [31:0] q);
        longint prod;
        prod = longint'(q) * cfg_dt;
        return clamp_q32(prod >>> 16);
    endfunction

    // returns {position, velocity} after the wall test on one axis
    function automatic logic [63:0] bounce_axis(input logic signed [31:0] p,
                                                input logic signed [31:0] v,
                                                input longint size);
        longint half;
        longint pos;
        longint ex;
        longint np;
        half = size >>> 1;
        pos  = longint'(p);
        ex   = -half - (pos - cfg_radius);
        if (ex > 0) begin
            np = (ex < SNAP_EXCESS) ? (cfg_radius - half) : (pos + 2 * ex);
        end else begin
            ex = pos + cfg_radius - half;
            if (ex <= 0) begin
                return {p, v};
            end
            np = (ex < SNAP_EXCESS) ? (half - cfg_radius) : (pos - 2 * ex);
        end
        return {clamp_q32(np), clamp_q32(-longint'(v))};
    endfunction

    function automatic drop_state_t advance_drop(input drop_cmd_t c);
        drop_state_t        r;
        int                 base;
        logic signed [31:0] pa [3];
        logic signed [31:0] va [3];
        base = 3 * (int'(c.idx) % DROP_COUNT);
        for (int k = 0; k < 3; k++) begin
            pa[k] = model_pos[base + k];
            va[k] = model_vel[base + k];
        end
        if (c.mode == MODE_PLACE) begin
            for (int k = 0; k < 3; k++) begin
                pa[k] = c.place[k];
                va[k] = '0;
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                va[k] = clamp_q32(longint'(va[k]) + longint'(scale_by_dt(c.accel[k])));
                pa[k] = clamp_q32(longint'(pa[k]) + longint'(scale_by_dt(va[k])));
            end
            {pa[1], va[1]} = bounce_axis(pa[1], va[1], cfg_height);
            {pa[0], va[0]} = bounce_axis(pa[0], va[0], cfg_width);
        end
        r.idx = c.idx;
        for (int k = 0; k < 3; k++) begin
            model_pos[base + k] = pa[k];
            model_vel[base + k] = va[k];
            r.pos[k] = pa[k];
            r.vel[k] = va[k];
        end
        return r;
    endfunction

    // command driver: one item per transfer, random gaps counted while the block is ready
    always @(posedge aclk) begin : cmd_driver
        drop_cmd_t cur_cmd;
        int        tx_wait;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_states.push_back(advance_drop(cur_cmd));
            end
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    s_tvalid <= 1'b0;
                    if (s_tready) begin
                        tx_wait--;
                    end
                end else if (cmd_queue.size() > 0) begin
                    cur_cmd = cmd_queue.pop_front();
                    s_tuser  <= cur_cmd.mode;
                    s_tdata  <= {6'b0, cur_cmd.accel, cur_cmd.place, cur_cmd.idx};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) begin
                        tx_calm = !tx_calm;
                    end
                    tx_wait = tx_calm ? 0 : $urandom_range(0, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_word(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
            error_count++;
        end
    endtask

    // result monitor: stall counts down only while a result is offered
    always @(posedge aclk) begin : result_monitor
        drop_state_t got;
        drop_state_t want;
        int          rx_wait;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.idx = m_tdata[9:0];
                got.pos = m_tdata[105:10];
                got.vel = m_tdata[201:106];
                if (expected_states.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none actual %h",
                             $time, got);
                    error_count++;
                end else begin
                    want = expected_states.pop_front();
                    check_word("out_index", 32'(want.idx), 32'(got.idx));
                    for (int k = 0; k < 3; k++) begin
                        check_word($sformatf("new_pos[%0d]", k), want.pos[k], got.pos[k]);
                        check_word($sformatf("new_vel[%0d]", k), want.vel[k], got.vel[k]);
                    end
                end
                if ($urandom_range(0, 63) == 0) begin
                    rx_calm = !rx_calm;
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
            end
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                if (m_tvalid) begin
                    rx_wait--;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (index)
            pibu_pkg::REG_TIME_STEP:   cfg_dt     = longint'(value & 32'h0001_FFFF);
            pibu_pkg::REG_BOX_WIDTH:   cfg_width  = longint'(value & 32'h7FFF_FFFF);
            pibu_pkg::REG_BOX_HEIGHT:  cfg_height = longint'(value & 32'h7FFF_FFFF);
            pibu_pkg::REG_DROP_RADIUS: cfg_radius = longint'(value & 32'h001F_FFFF);
            default: ;
        endcase
    endtask

    task automatic set_box(input logic [31:0] dt, input logic [31:0] width,
                           input logic [31:0] height, input logic [31:0] radius);
        write_register(pibu_pkg::REG_TIME_STEP, dt);
        write_register(pibu_pkg::REG_BOX_WIDTH, width);
        write_register(pibu_pkg::REG_BOX_HEIGHT, height);
        write_register(pibu_pkg::REG_DROP_RADIUS, radius);
    endtask

    // hold until every command is sent and every result is back, then settle
    task automatic drain();
        while (cmd_queue.size() > 0 || s_tvalid || expected_states.size() > 0) begin
            @(negedge aclk);
        end
        repeat (50) @(posedge aclk);
    endtask

    task automatic push_cmd(input logic mode, input int idx,
                            input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic [31:0] ax,
                            input logic [31:0] ay, input logic [31:0] az);
        drop_cmd_t c;
        c.mode  = mode;
        c.idx   = idx[9:0];
        c.place = {pz, py, px};
        c.accel = {az, ay, ax};
        cmd_queue.push_back(c);
    endtask

    function automatic logic [31:0] pick_coord(input longint half);
        longint v;
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: v = longint'($urandom()) % (2 * half + 1) - half;
            default: begin
                // around the inner wall line, both inside and beyond
                v = half - cfg_radius + longint'($urandom_range(0, 40000)) - 20000;
                if ($urandom_range(0, 1)) begin
                    v = -v;
                end
            end
        endcase
        return clamp_q32(v);
    endfunction

    function automatic logic [31:0] pick_accel();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return '0;
            default: return 32'($urandom_range(0, 32'h0080_0000) - 32'h0040_0000);
        endcase
    endfunction

    task automatic queue_random_cmd();
        longint hw;
        longint hh;
        int     idx;
        hw = cfg_width >>> 1;
        hh = cfg_height >>> 1;
        if (active_drops.size() == 0 || $urandom_range(0, 4) == 0) begin
            idx = $urandom_range(0, DROP_COUNT - 1);
            push_cmd(MODE_PLACE, idx, pick_coord(hw), pick_coord(hh), pick_coord(hh),
                     $urandom(), $urandom(), $urandom());
            active_drops.push_back(idx);
            if (active_drops.size() > 12) begin
                void'(active_drops.pop_front());
            end
        end else begin
            idx = active_drops[$urandom_range(0, active_drops.size() - 1)];
            push_cmd(MODE_STEP, idx, $urandom(), $urandom(), $urandom(),
                     pick_accel(), pick_accel(), pick_accel());
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset settings: walls at +-655360, radius 6554
        push_cmd(MODE_PLACE, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(MODE_STEP, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(MODE_PLACE, 1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
        push_cmd(MODE_STEP, 1023, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_cmd(MODE_STEP, 1023, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        // just past the walls: snap
        push_cmd(MODE_PLACE, 2, 32'sd648906, -32'sd648906, 0, 0, 0, 0);
        push_cmd(MODE_STEP, 2, 0, 0, 0, 0, 0, 0);
        // excess exactly at the snap limit reflects, one below snaps
        push_cmd(MODE_PLACE, 3, 32'sd655360, -32'sd655359, 0, 0, 0, 0);
        push_cmd(MODE_STEP, 3, 0, 0, 0, 0, 0, 0);
        push_cmd(MODE_PLACE, 4, 32'sd655359, -32'sd655360, 0, 0, 0, 0);
        push_cmd(MODE_STEP, 4, 0, 0, 0, 0, 0, 0);
        // touching the walls exactly: no hit
        push_cmd(MODE_PLACE, 5, -32'sd648806, 32'sd648806, 0, 0, 0, 0);
        push_cmd(MODE_STEP, 5, 0, 0, 0, 0, 0, 0);
        // deep beyond: reflect with velocity flip
        push_cmd(MODE_PLACE, 6, -32'sd698806, 32'sd698806, 32'h8000_0000, 0, 0, 0);
        push_cmd(MODE_STEP, 6, 0, 0, 0, 32'sh0010_0000, -32'sh0010_0000, 32'h8000_0000);
        push_cmd(MODE_STEP, 6, 0, 0, 0, 32'sh0010_0000, -32'sh0010_0000, 32'h8000_0000);
        push_cmd(MODE_PLACE, 341, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
                 32'hFFFF_FFFF, 32'h0, 32'h1);
        push_cmd(MODE_STEP, 341, 32'hFFFF_FFFF, 32'h0, 32'h1,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);
        push_cmd(MODE_PLACE, 682, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
        push_cmd(MODE_STEP, 682, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        push_cmd(MODE_PLACE, 512, 0, 0, 0, 0, 0, 0);
        push_cmd(MODE_STEP, 512, 0, 0, 0, 32'sh000A_0000, 32'sh000A_0000, 32'sh000A_0000);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            queue_random_cmd();
        end
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_box(32'h0, 32'h0, 32'h0, 32'h0);
                // all ones: every register at its top value after masking
                1: set_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: set_box(32'd65536, 32'd13107, 32'd1, 32'd1048576);
                3: set_box(32'd1092, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd6554);
                default: set_box($urandom_range(0, 131071), $urandom_range(0, 4000000),
                                 $urandom_range(0, 4000000), $urandom_range(0, 60000));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_random_cmd();
            end
            drain();
        end

        if (error_count == 0) begin
            $display("particle_integrate_and_bounce_unit: match");
        end else begin
            $display("particle_integrate_and_bounce_unit: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("particle_integrate_and_bounce_unit: mismatch");
        $finish;
    end

endmodule
